>>> hdl/base64_stream_encoder_core_defines.svh
// Assertion macros for the base64 stream encoder core
`ifndef BASE64_STREAM_ENCODER_CORE_DEFINES_SVH
`define BASE64_STREAM_ENCODER_CORE_DEFINES_SVH

`ifndef SYNTH
`define B64E_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("b64e assertion failed");
`define B64E_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b64e assertion failed");
`else
`define B64E_ASSERT(lbl, prop)
`define B64E_ASSERT_IMPLY(lbl, ante, cons)
`endif

`endif

>>> hdl/b64e_pkg.sv
// Shared types, constants and functions of the base64 stream encoder
`timescale 1ns / 1ps

package b64e_pkg;

  localparam logic [7:0] PadChar = 8'h3D;
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_in;
  } b64e_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } b64e_out_t;

  // One accepted byte turned into 1..4 characters
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      cnt_m1;
    logic            end_mark;
  } b64e_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64e_qstat_t;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } b64e_phase_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage

>>> hdl/b64e_front.sv
// Front end: accepts bytes, tracks group phase and builds character entries
`timescale 1ns / 1ps

module b64e_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  b64e_pkg::b64e_in_t   in_data,
  output logic                 in_stall,
  input  b64e_pkg::b64e_qstat_t q_stat,
  output logic                 q_wr,
  output b64e_pkg::b64e_entry_t q_wdata
);
  import b64e_pkg::*;

  b64e_phase_t phase_r, phase_nxt;
  logic [3:0]  carry_r, carry_nxt;
  logic [7:0]  b;
  logic        last;

  assign in_stall = q_stat.full;
  assign q_wr     = in_valid && !q_stat.full;
  assign b        = in_data.byte_in;
  assign last     = in_data.last_in;

  always_comb begin
    q_wdata   = '0;
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    case (phase_r)
      PH_SECOND: begin
        q_wdata.chars[0] = sextet_char({carry_r[1:0], b[7:4]});
        if (last) begin
          q_wdata.chars[1] = sextet_char({b[3:0], 2'b00});
          q_wdata.chars[2] = PadChar;
          q_wdata.cnt_m1   = 2'd2;
          q_wdata.end_mark = 1'b1;
          phase_nxt        = PH_FIRST;
          carry_nxt        = 4'd0;
        end else begin
          q_wdata.cnt_m1 = 2'd0;
          phase_nxt      = PH_THIRD;
          carry_nxt      = b[3:0];
        end
      end
      PH_THIRD: begin
        q_wdata.chars[0] = sextet_char({carry_r, b[7:6]});
        q_wdata.chars[1] = sextet_char(b[5:0]);
        q_wdata.cnt_m1   = 2'd1;
        q_wdata.end_mark = last;
        phase_nxt        = PH_FIRST;
        carry_nxt        = 4'd0;
      end
      default: begin
        q_wdata.chars[0] = sextet_char(b[7:2]);
        if (last) begin
          q_wdata.chars[1] = sextet_char({b[1:0], 4'b0000});
          q_wdata.chars[2] = PadChar;
          q_wdata.chars[3] = PadChar;
          q_wdata.cnt_m1   = 2'd3;
          q_wdata.end_mark = 1'b1;
          phase_nxt        = PH_FIRST;
          carry_nxt        = 4'd0;
        end else begin
          q_wdata.cnt_m1 = 2'd0;
          phase_nxt      = PH_SECOND;
          carry_nxt      = {2'b00, b[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      carry_r <= 4'd0;
    end else if (q_wr) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

`include "base64_stream_encoder_core_defines.svh"

  `B64E_ASSERT_IMPLY(a_first_no_carry, phase_r == PH_FIRST, carry_r == 4'd0)

endmodule

>>> hdl/b64e_fifo.sv
// Entry queue between front and back end
`timescale 1ns / 1ps

module b64e_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr,
  input  b64e_pkg::b64e_entry_t wdata,
  input  logic                  rd,
  output b64e_pkg::b64e_entry_t rdata,
  output b64e_pkg::b64e_qstat_t stat
);
  import b64e_pkg::*;

  b64e_entry_t      mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] cnt_r;

  assign stat.full  = (cnt_r == QCntW'(QDepth));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`include "base64_stream_encoder_core_defines.svh"

  `B64E_ASSERT_IMPLY(a_no_push_full, wr, !stat.full)
  `B64E_ASSERT_IMPLY(a_no_pop_empty, rd, !stat.empty)
  `B64E_ASSERT(a_cnt_ptr, cnt_r == QCntW'(QDepth) || QPtrW'(wr_ptr_r - rd_ptr_r) == QPtrW'(cnt_r))

endmodule

>>> hdl/b64e_back.sv
// Back end: emits one character per cycle from queued entries while the output is not stalled
`timescale 1ns / 1ps

module b64e_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  b64e_pkg::b64e_qstat_t q_stat,
  input  b64e_pkg::b64e_entry_t q_rdata,
  output logic                  q_rd,
  output logic                  out_valid,
  output b64e_pkg::b64e_out_t   out_data,
  input  logic                  out_stall
);
  import b64e_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  b64e_out_t   out_data_r, out_data_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        load;
  logic        at_end;

  assign load      = !q_stat.empty && (!out_valid_r || !out_stall);
  assign at_end    = (idx_r == q_rdata.cnt_m1);
  assign q_rd      = load && at_end;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.out_char = q_rdata.chars[idx_r];
      out_data_nxt.out_last = q_rdata.end_mark && at_end;
      idx_nxt               = at_end ? 2'd0 : idx_r + 2'd1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`include "base64_stream_encoder_core_defines.svh"

  `B64E_ASSERT_IMPLY(a_idx_in_entry, !q_stat.empty, idx_r <= q_rdata.cnt_m1)

endmodule

>>> hdl/base64_stream_encoder_core.sv
// Top level of the streaming base64 encoder
//
//  channel | direction | payload                      | handshake
//  in      | input     | byte_in[7:0], last_in        | in_valid / in_stall
//  out     | output    | out_char[7:0], out_last      | out_valid / out_stall
//
// A byte is taken each cycle while the entry queue has room; it yields 1 to 4
// characters. The output register emits one character per cycle while out_stall
// is low, so the sustained byte rate is set by the character count.
// The first character passes through the entry queue and then the output register before it is valid.
// Synchronous active-low reset clears phase, queue and output valid.
// Output stall backs up the queue (4 entries) and then raises in_stall.
`timescale 1ns / 1ps

module base64_stream_encoder_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  b64e_pkg::b64e_in_t  in_data,
  output logic                in_stall,
  output logic                out_valid,
  output b64e_pkg::b64e_out_t out_data,
  input  logic                out_stall
);
  import b64e_pkg::*;

  b64e_qstat_t q_stat;
  b64e_entry_t q_wdata, q_rdata;
  logic        q_wr, q_rd;

  b64e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_stat   (q_stat),
    .q_wr     (q_wr),
    .q_wdata  (q_wdata)
  );

  b64e_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_rd      (q_rd),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
